[hdl/msl_pkg.sv]
// Package for the motor speed slew limiter: request and response structs,
// function and drive codes, default parameter values. Depends on nothing.
`default_nettype none

package msl_pkg;

  // Default parameter values
  localparam int unsigned SPEED_FRAC_BITS_DEF = 14;
  localparam int unsigned TIME_BITS_DEF       = 24;

  // Fixed field widths
  localparam int unsigned ACCEL_W   = 24;
  localparam int unsigned ELAPSED_W = 24;
  localparam int unsigned TARGET_W  = 16;
  localparam int unsigned SPEED_O_W = 16;
  localparam int unsigned DUTY_W    = 15;

  // Duty full scale is 2^DUTY_FULL_BITS, step product carries RATE_SHIFT fraction bits
  localparam int unsigned DUTY_FULL_BITS = 14;
  localparam int unsigned RATE_SHIFT     = 16;

  typedef enum logic [1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_TARGET = 2'd1,
    FUNC_BRAKE  = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    MODE_COAST   = 2'd0,
    MODE_FORWARD = 2'd1,
    MODE_REVERSE = 2'd2,
    MODE_BRAKE   = 2'd3
  } drive_mode_e;

  typedef struct packed {
    logic [1:0]                 func;
    logic signed [TARGET_W-1:0] target_value;
    logic [ELAPSED_W-1:0]       elapsed_us;
  } in_req_t;

  typedef struct packed {
    logic signed [SPEED_O_W-1:0] current_speed;
    logic [1:0]                  drive_mode;
    logic [DUTY_W-1:0]           duty_magnitude;
  } out_rsp_t;

endpackage

`default_nettype wire

[hdl/msl_prep.sv]
// Input stage of the slew limiter: acceleration register, step product with
// saturation, target clamp, and the input request register. Uses msl_pkg.
`default_nettype none

module msl_prep #(
  parameter int unsigned SPEED_FRAC_BITS = msl_pkg::SPEED_FRAC_BITS_DEF,
  parameter int unsigned TIME_BITS       = msl_pkg::TIME_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic [msl_pkg::ACCEL_W-1:0]       cfg_data_i,
  input  logic                              in_valid_i,
  input  msl_pkg::in_req_t                  in_req_i,
  output logic                              in_stall_o,
  input  logic                              adv_i,
  output logic                              s1_valid_o,
  output logic [1:0]                        s1_func_o,
  output logic signed [SPEED_FRAC_BITS+1:0] s1_target_o,
  output logic [SPEED_FRAC_BITS+2:0]        s1_step_o
);
  import msl_pkg::*;

  localparam int unsigned SPEED_W = SPEED_FRAC_BITS + 2;
  localparam int unsigned STEP_W  = SPEED_FRAC_BITS + 3;
  localparam int unsigned DT_W    = (TIME_BITS < ELAPSED_W) ? TIME_BITS : ELAPSED_W;
  localparam int unsigned PROD_W  = ACCEL_W + DT_W;
  localparam int unsigned SHR_W   = PROD_W - RATE_SHIFT;
  localparam int unsigned CMP_W   = (SHR_W > STEP_W) ? SHR_W : STEP_W;
  localparam int unsigned TW      = (SPEED_W > TARGET_W + 1) ? SPEED_W : TARGET_W + 1;

  localparam logic [CMP_W-1:0]     STEP_MAX = CMP_W'(1) << (SPEED_FRAC_BITS + 2);
  localparam logic signed [TW-1:0] FULL_T   = TW'(1) << SPEED_FRAC_BITS;

  logic [ACCEL_W-1:0] accel_q;
  logic               s1_valid_q;
  logic [1:0]         func_q;
  logic signed [SPEED_W-1:0] target_q, target_d;
  logic [STEP_W-1:0]  step_q, step_d;

  logic [DT_W-1:0]       dt;
  logic [PROD_W-1:0]     prod;
  logic [CMP_W-1:0]      step_full;
  logic signed [TW-1:0]  tgt_w;
  logic                  en;

  assign dt        = in_req_i.elapsed_us[DT_W-1:0];
  assign prod      = PROD_W'(accel_q) * PROD_W'(dt);
  assign step_full = CMP_W'(prod >> RATE_SHIFT);
  assign step_d    = (step_full > STEP_MAX) ? STEP_MAX[STEP_W-1:0] : step_full[STEP_W-1:0];

  always_comb begin
    tgt_w = TW'(in_req_i.target_value);
    if (tgt_w > FULL_T) begin
      target_d = FULL_T[SPEED_W-1:0];
    end else if (tgt_w < -FULL_T) begin
      target_d = SPEED_W'(-FULL_T);
    end else begin
      target_d = tgt_w[SPEED_W-1:0];
    end
  end

  // Stage loads when empty or when its request moves on
  assign en         = !s1_valid_q || adv_i;
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_q    <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        accel_q <= cfg_data_i;
      end
      if (en) begin
        s1_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && in_valid_i) begin
      func_q   <= in_req_i.func;
      target_q <= target_d;
      step_q   <= step_d;
    end
  end

  assign s1_valid_o  = s1_valid_q;
  assign s1_func_o   = func_q;
  assign s1_target_o = target_q;
  assign s1_step_o   = step_q;

endmodule

`default_nettype wire

[hdl/msl_ramp.sv]
// Ramp stage of the slew limiter: speed and goal state, H-bridge drive
// derivation and the response register. Uses msl_pkg.
`default_nettype none

module msl_ramp #(
  parameter int unsigned SPEED_FRAC_BITS = msl_pkg::SPEED_FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s1_valid_i,
  input  logic [1:0]                        s1_func_i,
  input  logic signed [SPEED_FRAC_BITS+1:0] s1_target_i,
  input  logic [SPEED_FRAC_BITS+2:0]        s1_step_i,
  output logic                              adv_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output msl_pkg::out_rsp_t                 out_rsp_o
);
  import msl_pkg::*;

  localparam int unsigned SPEED_W = SPEED_FRAC_BITS + 2;
  localparam int unsigned MAG_W   = SPEED_FRAC_BITS + 1;
  localparam int unsigned WIDE    = SPEED_FRAC_BITS + 4;
  localparam int unsigned DWIDE   = MAG_W + DUTY_FULL_BITS;

  localparam logic signed [WIDE-1:0] FULL_W = WIDE'(1) << SPEED_FRAC_BITS;
  localparam logic [DUTY_W-1:0]      DUTY_MAX = DUTY_W'(1) << DUTY_FULL_BITS;

  logic signed [SPEED_W-1:0] ramp_q, ramp_d, goal_q, goal_d;
  logic [1:0]                mode_q, mode_d;
  logic [DUTY_W-1:0]         duty_q, duty_d;
  logic                      out_valid_q;
  out_rsp_t                  rsp_q;
  logic                      load;

  assign adv_o = !(out_valid_q && out_stall_i);
  assign load  = adv_o && s1_valid_i;

  always_comb begin
    logic signed [WIDE-1:0] ramp_w;
    logic signed [WIDE-1:0] goal_w;
    logic signed [WIDE-1:0] step_w;
    logic signed [WIDE-1:0] diff;
    logic signed [WIDE-1:0] gap;
    logic signed [WIDE-1:0] moved;
    logic signed [SPEED_W-1:0] nxt;
    logic signed [SPEED_W-1:0] abs_s;
    logic [DWIDE-1:0]          duty_w;

    ramp_d = ramp_q;
    goal_d = goal_q;
    mode_d = mode_q;
    duty_d = duty_q;

    ramp_w = WIDE'(ramp_q);
    goal_w = WIDE'(goal_q);
    step_w = $signed({1'b0, s1_step_i});
    diff   = goal_w - ramp_w;
    gap    = diff[WIDE-1] ? -diff : diff;
    moved  = diff[WIDE-1] ? ramp_w - step_w : ramp_w + step_w;

    // Step toward the goal and clamp, or snap when within one step
    if (gap > step_w) begin
      if (moved > FULL_W) begin
        nxt = FULL_W[SPEED_W-1:0];
      end else if (moved < -FULL_W) begin
        nxt = SPEED_W'(-FULL_W);
      end else begin
        nxt = moved[SPEED_W-1:0];
      end
    end else begin
      nxt = goal_q;
    end

    abs_s  = nxt[SPEED_W-1] ? -nxt : nxt;
    duty_w = {abs_s[MAG_W-1:0], DUTY_FULL_BITS'(0)} >> SPEED_FRAC_BITS;

    case (s1_func_i)
      FUNC_TICK: begin
        ramp_d = nxt;
        if (nxt == '0) begin
          mode_d = MODE_COAST;
          duty_d = '0;
        end else begin
          mode_d = nxt[SPEED_W-1] ? MODE_REVERSE : MODE_FORWARD;
          duty_d = (DWIDE'(duty_w) > DWIDE'(DUTY_MAX)) ? DUTY_MAX : duty_w[DUTY_W-1:0];
        end
      end
      FUNC_TARGET: begin
        goal_d = s1_target_i;
      end
      FUNC_BRAKE: begin
        ramp_d = '0;
        goal_d = '0;
        mode_d = MODE_BRAKE;
        duty_d = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_q      <= '0;
      goal_q      <= '0;
      mode_q      <= MODE_COAST;
      duty_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv_o) begin
        out_valid_q <= s1_valid_i;
      end
      if (load) begin
        ramp_q <= ramp_d;
        goal_q <= goal_d;
        mode_q <= mode_d;
        duty_q <= duty_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rsp_q.current_speed  <= SPEED_O_W'(ramp_d);
      rsp_q.drive_mode     <= mode_d;
      rsp_q.duty_magnitude <= duty_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  a_coast_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_COAST |-> (ramp_q == '0 && duty_q == '0))
    else $error("coast with nonzero speed or duty");

  a_brake_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_BRAKE |-> (ramp_q == '0 && duty_q == '0))
    else $error("brake with nonzero speed or duty");

  a_speed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (WIDE'(ramp_q) <= FULL_W) && (WIDE'(ramp_q) >= -FULL_W)
    && (WIDE'(goal_q) <= FULL_W) && (WIDE'(goal_q) >= -FULL_W))
    else $error("speed state outside full scale");

  a_drive_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != MODE_FORWARD || ramp_q > 0) && (mode_q != MODE_REVERSE || ramp_q < 0))
    else $error("drive direction disagrees with speed sign");

  a_state_only_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !load |=> $stable(ramp_q) && $stable(goal_q) && $stable(mode_q))
    else $error("state changed without a request");

endmodule

`default_nettype wire

[hdl/motor_speed_slew_limiter.sv]
// Top level of the motor speed slew limiter: connects the input stage and
// the ramp stage. Uses msl_pkg, msl_prep and msl_ramp.
`default_nettype none

// Slew-rate limited DC motor speed with H-bridge drive. Each request gives
// exactly one response: a tick (func 0) moves the speed toward the goal by
// (accel_rate * elapsed_us) >> 16, saturated at four times full scale, and
// snaps to the goal when within one step; a set-target (func 1) clamps and
// stores the goal and repeats the present drive; a brake (func 2) zeroes both
// speeds and drives both legs high until the next tick; code three leaves the
// state alone. Speeds are signed with SPEED_FRAC_BITS fraction bits, full scale
// 2^SPEED_FRAC_BITS; duty is scaled so that 16384 is 100 percent.
// Timing: one request per cycle sustained while out_stall_i is low; an accepted
// request goes to the input register and then to the output register. The step
// multiplier (24 by up to 24 bits) and the target clamp sit in front of the
// input register; the subtract, compare and clamp that close the loop on the
// speed state sit between the input and the output register. A waiting
// response does not block the next request if the input register is empty:
// the input register takes it while the output register holds.
// Write accel_rate only while no request is in flight.

module motor_speed_slew_limiter #(
  parameter int unsigned SPEED_FRAC_BITS = msl_pkg::SPEED_FRAC_BITS_DEF,
  parameter int unsigned TIME_BITS       = msl_pkg::TIME_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [msl_pkg::ACCEL_W-1:0] cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  msl_pkg::in_req_t            in_req_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output msl_pkg::out_rsp_t           out_rsp_o
);
  import msl_pkg::*;

  logic                              adv;
  logic                              s1_valid;
  logic [1:0]                        s1_func;
  logic signed [SPEED_FRAC_BITS+1:0] s1_target;
  logic [SPEED_FRAC_BITS+2:0]        s1_step;

  // Register write is always accepted
  assign cfg_ready_o = 1'b1;

  // Register the request, form the step and clamp the target
  msl_prep #(
    .SPEED_FRAC_BITS (SPEED_FRAC_BITS),
    .TIME_BITS       (TIME_BITS)
  ) u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_req_i    (in_req_i),
    .in_stall_o  (in_stall_o),
    .adv_i       (adv),
    .s1_valid_o  (s1_valid),
    .s1_func_o   (s1_func),
    .s1_target_o (s1_target),
    .s1_step_o   (s1_step)
  );

  // Advance the speed state and register the response
  msl_ramp #(
    .SPEED_FRAC_BITS (SPEED_FRAC_BITS)
  ) u_ramp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s1_valid_i  (s1_valid),
    .s1_func_i   (s1_func),
    .s1_target_i (s1_target),
    .s1_step_i   (s1_step),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

`default_nettype wire
